FILE: rtl/core/psmv_pkg.sv
package psmv_pkg;

  // Default sizes for the top-level parameters.
  localparam int VecSizeDef   = 1024;
  localparam int DataWidthDef = 32;

  // Fixed widths of the words on the ports.
  localparam int CmdW   = 2;
  localparam int IdxW   = 10;
  localparam int FieldW = 32;
  localparam int PaddrW = 3;

  // Input command codes.
  localparam logic [CmdW-1:0] CMD_LOAD_X  = 2'd0;
  localparam logic [CmdW-1:0] CMD_LOAD_Y  = 2'd1;
  localparam logic [CmdW-1:0] CMD_NONZERO = 2'd2;
  localparam logic [CmdW-1:0] CMD_FINISH  = 2'd3;

  // Configuration register indexes (word address bit 2).
  localparam logic REG_ALPHA = 1'b0;
  localparam logic REG_BETA  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the incoming word
    logic mem_step;  // memory read or load write
    logic acc_add;   // add the x entry to the row sum
    logic mul_step;  // form both products
    logic finish;    // emit the result, write back y, clear the row sum
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_nonzero;
    logic is_finish;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: rtl/core/psmv_ctrl.sv
module psmv_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  psmv_pkg::dp_sts_t sts_i,
  output psmv_pkg::dp_cmd_t cmd_o
);
  import psmv_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MEM  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_SUM  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_MEM;
        end
      end
      S_MEM: begin
        cmd_o.mem_step = 1'b1;
        if (sts_i.is_nonzero || sts_i.is_finish) begin
          state_d = S_MUL;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MUL: begin
        if (sts_i.is_finish) begin
          cmd_o.mul_step = 1'b1;
          state_d        = S_SUM;
        end else begin
          cmd_o.acc_add = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_SUM: begin
        // Hold here until the output register can take the result.
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

FILE: rtl/core/psmv_dp.sv
module psmv_dp #(
  parameter int VEC_SIZE   = psmv_pkg::VecSizeDef,
  parameter int DATA_WIDTH = psmv_pkg::DataWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  psmv_pkg::dp_cmd_t                 cmd_i,
  output psmv_pkg::dp_sts_t                 sts_o,
  input  logic [psmv_pkg::CmdW-1:0]         in_cmd_i,
  input  logic [psmv_pkg::IdxW-1:0]         in_index_i,
  input  logic signed [psmv_pkg::FieldW-1:0] in_value_i,
  input  logic signed [psmv_pkg::FieldW-1:0] alpha_i,
  input  logic signed [psmv_pkg::FieldW-1:0] beta_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic [psmv_pkg::IdxW-1:0]         row_o,
  output logic signed [psmv_pkg::FieldW-1:0] y_value_o
);
  import psmv_pkg::*;

  // Only the low word of any value reaches the output, so the arithmetic
  // and the stores are kept no wider than the output word.
  localparam int CalcW = (DATA_WIDTH < FieldW) ? DATA_WIDTH : FieldW;
  localparam int AddrW = $clog2(VEC_SIZE);

  logic [CalcW-1:0] x_mem [VEC_SIZE];
  logic [CalcW-1:0] y_mem [VEC_SIZE];

  logic [CmdW-1:0]  cmd_q;
  logic [IdxW-1:0]  idx_q;
  logic [AddrW-1:0] addr_q;
  logic [CalcW-1:0] val_q;
  logic             ok_q;
  logic [CalcW-1:0] x_rd_q;
  logic [CalcW-1:0] y_rd_q;
  logic [CalcW-1:0] acc_q;
  logic [CalcW-1:0] prod_b_q;
  logic [CalcW-1:0] prod_a_q;
  logic             out_valid_q;
  logic [IdxW-1:0]  row_q;
  logic [CalcW-1:0] y_q;

  logic             x_we;
  logic             y_we;
  logic [CalcW-1:0] y_wdata;
  logic [CalcW-1:0] sum_d;
  logic [CalcW-1:0] alpha_c;
  logic [CalcW-1:0] beta_c;
  logic [CalcW-1:0] old_y;
  logic [CalcW-1:0] x_add;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= in_cmd_i;
      idx_q  <= in_index_i;
      addr_q <= AddrW'(in_index_i);
      val_q  <= CalcW'(in_value_i);
      ok_q   <= (32'(in_index_i) < 32'(VEC_SIZE));
    end
  end

  assign x_we    = cmd_i.mem_step && (cmd_q == CMD_LOAD_X) && ok_q;
  assign y_we    = (cmd_i.mem_step && (cmd_q == CMD_LOAD_Y) && ok_q) ||
                   (cmd_i.finish && ok_q);
  assign y_wdata = cmd_i.finish ? sum_d : val_q;

  always_ff @(posedge clk_i) begin
    if (x_we) begin
      x_mem[addr_q] <= val_q;
    end
    if (cmd_i.mem_step) begin
      x_rd_q <= x_mem[addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (y_we) begin
      y_mem[addr_q] <= y_wdata;
    end
    if (cmd_i.mem_step) begin
      y_rd_q <= y_mem[addr_q];
    end
  end

  // Indexes past the end of the vector read as zero.
  assign x_add   = ok_q ? x_rd_q : '0;
  assign old_y   = ok_q ? y_rd_q : '0;
  assign alpha_c = CalcW'(alpha_i);
  assign beta_c  = CalcW'(beta_i);
  assign sum_d   = prod_b_q + prod_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + x_add;
    end else if (cmd_i.finish) begin
      acc_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_step) begin
      prod_b_q <= beta_c * old_y;
      prod_a_q <= alpha_c * acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      row_q <= idx_q;
      y_q   <= sum_d;
    end
  end

  assign sts_o.is_nonzero = (cmd_q == CMD_NONZERO);
  assign sts_o.is_finish  = (cmd_q == CMD_FINISH);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign row_o       = row_q;
  assign y_value_o   = FieldW'(y_q);

endmodule

FILE: rtl/core/pattern_sparse_matvec_int_unit.sv
// Channel   Direction  Handshake              Word
// in        input      in_valid_i/in_stall_o  cmd_i, index_i, value_i
// out       output     out_valid_o/out_stall_i row_o, y_value_o
// config    input      APB psel/penable       paddr, pwdata, prdata (alpha, beta)
//
// One word is taken at a time. Each word is captured and then passes the
// registered memory read; a nonzero then adds its x entry to the row sum, and a
// row finish forms both products, then adds them once the output is free.
// Reset is asynchronous and active low; it clears the controller, the row
// sum, the output valid flag and sets alpha to one and beta to zero.
// The x and y stores are not cleared and need no clearing pass.
// A finished result sits in the output register while the next word is
// taken; a finish only waits if that register is still stalled.
module pattern_sparse_matvec_int_unit #(
  parameter int VEC_SIZE   = psmv_pkg::VecSizeDef,
  parameter int DATA_WIDTH = psmv_pkg::DataWidthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input channel.
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [psmv_pkg::CmdW-1:0]          cmd_i,
  input  logic [psmv_pkg::IdxW-1:0]          index_i,
  input  logic signed [psmv_pkg::FieldW-1:0] value_i,
  // Output channel.
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [psmv_pkg::IdxW-1:0]          row_o,
  output logic signed [psmv_pkg::FieldW-1:0] y_value_o,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [psmv_pkg::PaddrW-1:0]        paddr,
  input  logic [psmv_pkg::FieldW-1:0]        pwdata,
  output logic [psmv_pkg::FieldW-1:0]        prdata,
  output logic                               pready
);
  import psmv_pkg::*;

  logic signed [FieldW-1:0] alpha_q;
  logic signed [FieldW-1:0] beta_q;
  logic                     cfg_we;
  dp_cmd_t                  dp_cmd;
  dp_sts_t                  dp_sts;

  // Registers are word aligned; address bit 2 picks alpha or beta.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= FieldW'(1);
      beta_q  <= '0;
    end else if (cfg_we) begin
      if (paddr[2] == REG_ALPHA) begin
        alpha_q <= pwdata;
      end else begin
        beta_q <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == REG_BETA) ? beta_q : alpha_q;

  psmv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  psmv_dp #(
    .VEC_SIZE   (VEC_SIZE),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .in_cmd_i    (cmd_i),
    .in_index_i  (index_i),
    .in_value_i  (value_i),
    .alpha_i     (alpha_q),
    .beta_i      (beta_q),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .row_o       (row_o),
    .y_value_o   (y_value_o)
  );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

// Testbench for the pattern sparse matrix-vector unit. Words are pushed into the
// input channel, and a predictor in this file follows each accepted word. Every
// finish word queues the row result that the block must give back, and a checker
// process compares each accepted output word against the oldest queued row.
module testbench;
  import psmv_pkg::*;

  // One expected output word: the finished row and its new y entry.
  typedef struct packed {
    logic [IdxW-1:0]   row;
    logic [FieldW-1:0] y_value;
  } row_result_t;

  // Clock, reset and every block input start at known values.
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic [CmdW-1:0]   cmd_i       = CMD_LOAD_X;
  logic [IdxW-1:0]   index_i     = '0;
  logic [FieldW-1:0] value_i     = '0;
  logic              out_stall_i = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [PaddrW-1:0] paddr       = '0;
  logic [FieldW-1:0] pwdata      = '0;

  logic              in_stall_o;
  logic              out_valid_o;
  logic [IdxW-1:0]   row_o;
  logic [FieldW-1:0] y_value_o;
  logic [FieldW-1:0] prdata;
  logic              pready;

  // Predictor state: both vectors, which entries hold data, the row sum and
  // the two scale registers as the block should hold them.
  logic [FieldW-1:0] x_mem [VecSizeDef];
  logic [FieldW-1:0] y_mem [VecSizeDef];
  bit                x_loaded [VecSizeDef];
  bit                y_loaded [VecSizeDef];
  int                x_cols [$];
  int                y_rows [$];
  logic [FieldW-1:0] row_acc = '0;
  logic [FieldW-1:0] alpha_q = 32'd1;
  logic [FieldW-1:0] beta_q  = '0;

  // Rows finished by the predictor whose output word has not arrived yet.
  row_result_t pending_rows [$];

  int mismatch_count = 0;
  int sent_words     = 0;
  int send_idle_pct  = 20;
  int recv_idle_pct  = 57;

  pattern_sparse_matvec_int_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .row_o       (row_o),
    .y_value_o   (y_value_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver stalls at random. A stall level of zero means that every
  // output word is taken as soon as it shows up.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Follow one accepted word. Arithmetic is 32 bits wide, so the products and
  // the sum wrap exactly as the block's two's complement datapath does.
  task automatic apply_word(input logic [CmdW-1:0] cmd, input logic [IdxW-1:0] idx,
                            input logic [FieldW-1:0] val);
    logic [FieldW-1:0] new_y;
    case (cmd)
      CMD_LOAD_X: begin
        if (!x_loaded[idx]) x_cols.push_back(int'(idx));
        x_loaded[idx] = 1'b1;
        x_mem[idx]    = val;
      end
      CMD_LOAD_Y: begin
        if (!y_loaded[idx]) y_rows.push_back(int'(idx));
        y_loaded[idx] = 1'b1;
        y_mem[idx]    = val;
      end
      CMD_NONZERO: begin
        row_acc = row_acc + x_mem[idx];
      end
      CMD_FINISH: begin
        new_y     = beta_q * y_mem[idx] + alpha_q * row_acc;
        y_mem[idx] = new_y;
        row_acc   = '0;
        pending_rows.push_back('{row: idx, y_value: new_y});
      end
    endcase
  endtask

  // Present one word and hold it until the block takes it. An idle gap lowers
  // valid first; otherwise valid stays high straight from the previous word.
  task automatic send_word(input logic [CmdW-1:0] cmd, input logic [IdxW-1:0] idx,
                           input logic [FieldW-1:0] val);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    index_i    <= idx;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    apply_word(cmd, idx, val);
    sent_words++;
  endtask

  // Stop sending and wait until every queued row has come back. A load or a
  // nonzero gives no output word, so a few more cycles cover the longest word
  // that might still be in flight.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // One register write: a setup cycle, then an access cycle that completes on
  // the edge at which pready is high.
  task automatic write_reg(input logic sel, input logic [FieldW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_ALPHA) alpha_q = data;
    else beta_q = data;
    @(posedge clk_i);
  endtask

  task automatic set_scales(input logic [FieldW-1:0] alpha, input logic [FieldW-1:0] beta);
    settle_block();
    write_reg(REG_ALPHA, alpha);
    write_reg(REG_BETA, beta);
  endtask

  // Values lean toward the corners of the signed range, where wrapping shows.
  function automatic logic [FieldW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // A well-formed row: its y entry is loaded if it was never written (or
  // sometimes reloaded), each nonzero points at an x entry that holds data,
  // and a finish closes the row. New x entries are loaded along the way.
  task automatic run_row(input int nz_count);
    int r;
    int c;
    if (y_rows.size() != 0 && $urandom_range(0, 1) == 0)
      r = y_rows[$urandom_range(0, y_rows.size() - 1)];
    else
      r = $urandom_range(0, VecSizeDef - 1);
    if (!y_loaded[r] || $urandom_range(0, 99) < 30)
      send_word(CMD_LOAD_Y, IdxW'(r), pick_value());
    for (int n = 0; n < nz_count; n++) begin
      if (x_cols.size() == 0 || $urandom_range(0, 2) == 0) begin
        c = $urandom_range(0, VecSizeDef - 1);
        send_word(CMD_LOAD_X, IdxW'(c), pick_value());
      end else begin
        c = x_cols[$urandom_range(0, x_cols.size() - 1)];
      end
      send_word(CMD_NONZERO, IdxW'(c), $urandom());
    end
    send_word(CMD_FINISH, IdxW'(r), $urandom());
  endtask

  // Noise between rows: stray loads anywhere, a lone nonzero that leaks into
  // the next row's sum, or a finish with nothing accumulated.
  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_word(CMD_LOAD_X, IdxW'($urandom_range(0, VecSizeDef - 1)), pick_value());
      1: send_word(CMD_LOAD_Y, IdxW'($urandom_range(0, VecSizeDef - 1)), pick_value());
      2: begin
        if (x_cols.size() != 0)
          send_word(CMD_NONZERO, IdxW'(x_cols[$urandom_range(0, x_cols.size() - 1)]),
                    $urandom());
      end
      default: begin
        if (y_rows.size() != 0)
          send_word(CMD_FINISH, IdxW'(y_rows[$urandom_range(0, y_rows.size() - 1)]),
                    $urandom());
      end
    endcase
  endtask

  // Directed words under the reset scales (alpha one, beta zero): extreme
  // indexes and values, every command, an empty row, a sum that wraps, an
  // overwritten x entry, and junk in the value field of nonzero and finish.
  task automatic test_directed();
    send_word(CMD_LOAD_X, 10'd0, 32'h7fff_ffff);
    send_word(CMD_LOAD_X, 10'd1023, 32'h8000_0000);
    send_word(CMD_LOAD_X, 10'd5, 32'hffff_ffff);
    send_word(CMD_LOAD_X, 10'd512, 32'h0000_0001);
    send_word(CMD_LOAD_Y, 10'd0, 32'h8000_0000);
    send_word(CMD_LOAD_Y, 10'd1023, 32'h7fff_ffff);
    send_word(CMD_LOAD_Y, 10'd7, 32'hffff_ffff);
    // Empty row: the finish sees a zero row sum.
    send_word(CMD_FINISH, 10'd7, 32'hdead_beef);
    // Largest plus smallest plus largest wraps around.
    send_word(CMD_NONZERO, 10'd0, 32'hffff_ffff);
    send_word(CMD_NONZERO, 10'd1023, 32'h5555_5555);
    send_word(CMD_NONZERO, 10'd0, 32'haaaa_aaaa);
    send_word(CMD_FINISH, 10'd0, 32'h0000_0000);
    send_word(CMD_NONZERO, 10'd5, 32'h8000_0000);
    send_word(CMD_NONZERO, 10'd512, 32'h7fff_ffff);
    send_word(CMD_FINISH, 10'd1023, 32'hffff_ffff);
    // An overwritten x entry must be the one that gets summed.
    send_word(CMD_LOAD_X, 10'd0, 32'h0000_0003);
    send_word(CMD_NONZERO, 10'd0, 32'h1234_5678);
    send_word(CMD_NONZERO, 10'd5, 32'h0);
    send_word(CMD_FINISH, 10'd0, 32'h0);
    // The pause in settle_block lets every result drain before more input.
    settle_block();
  endtask

  // Run a few rows under each pair of scales, the signed extremes among them,
  // including a zero alpha and an alpha that does not divide beta.
  task automatic test_scale_sweep();
    logic [FieldW-1:0] alphas [8] = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                      32'hffff_ffff, 32'h0000_0003, 32'h0000_0007,
                                      32'h0000_0001, 32'h0000_0002};
    logic [FieldW-1:0] betas [8]  = '{32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff,
                                      32'h0000_0001, 32'h0000_0006, 32'h0000_0005,
                                      32'h0000_0000, 32'h8000_0001};
    for (int s = 0; s < 8; s++) begin
      set_scales(alphas[s], betas[s]);
      for (int k = 0; k < 4; k++) run_row($urandom_range(0, 4));
    end
  endtask

  // The bulk of the stimulus, in three idle profiles: sender rarely idle and
  // receiver often stalled, then the reverse, then no idling on either side.
  // Random scales are written between the profiles while the block is idle.
  task automatic test_random_stream();
    int phase_end;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_end = sent_words + 100;
      while (sent_words < phase_end) begin
        if ($urandom_range(0, 99) < 80) run_row($urandom_range(0, 6));
        else send_noise();
      end
      set_scales($urandom(), $urandom());
    end
  endtask

  // Each taken output word must match the oldest row still queued.
  always @(posedge clk_i) begin : check_rows
    row_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rows.size() == 0) begin
        $display("%0t: unexpected row %0d y %0d", $time, row_o, $signed(y_value_o));
        mismatch_count++;
      end else begin
        want = pending_rows.pop_front();
        if (row_o !== want.row) begin
          $display("%0t: row expected %0d actual %0d", $time, want.row, row_o);
          mismatch_count++;
        end
        if (y_value_o !== want.y_value) begin
          $display("%0t: row %0d y expected %0d actual %0d", $time, want.row,
                   $signed(want.y_value), $signed(y_value_o));
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_scale_sweep();
    test_random_stream();
    settle_block();
    if (mismatch_count == 0) begin
      $display("pattern_sparse_matvec_int_unit: match");
    end else begin
      $display("pattern_sparse_matvec_int_unit: mismatch");
    end
    $finish;
  end

  // A run far longer than the slowest correct one means the block hung.
  initial begin
    #2000000;
    $display("pattern_sparse_matvec_int_unit: mismatch");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/psmv_pkg.sv
rtl/core/psmv_ctrl.sv
rtl/core/psmv_dp.sv
rtl/core/pattern_sparse_matvec_int_unit.sv
sim/testbench.sv
